// ===== rtl/core/ideq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed deque package
// Field widths, operation and status codes, default sizes and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ideq_pkg;

   // Field widths of one transaction on each channel.
   localparam int DATA_W = 64;
   localparam int IDX_W  = 11;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 11;

   // Default store size and renumbering step.
   localparam int DEPTH_DEF = 1024;
   localparam int STEP_DEF  = 64;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_GET     = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT     = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH    = 3'd2;
   localparam logic [OP_W-1:0] OP_POP     = 3'd3;
   localparam logic [OP_W-1:0] OP_UNSHIFT = 3'd4;
   localparam logic [OP_W-1:0] OP_SHIFT   = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic accept;
      logic finish;
   } ideq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
   } ideq_stat_type;

endpackage

// ===== rtl/core/ideq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module ideq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ideq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed deque controller
// Sequences the clearing sweep after reset, the acceptance of a request and
// the hand-over of its response into the output register.
// ----------------------------------------------------------------------------
module ideq_ctrl
   import ideq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ideq_cmd_type  cmd,
   input  ideq_stat_type stat
);

   typedef enum logic [2:0] {
      S_CLEAR  = 3'b001,
      S_IDLE   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      finish;

   // Requests are taken only when idle; a response waits in the output
   // register without holding up the next request.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign cmd.clear_step = (state_ff == S_CLEAR);
   assign cmd.accept     = accept;
   assign cmd.finish     = finish;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Output register occupancy.
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/ideq_datapath.sv =====
// ----------------------------------------------------------------------------
// Indexed deque datapath
// Holds the window pointers and the base offset, decodes each request into at
// most one store access at acceptance and the pointer updates, builds the response.
// ----------------------------------------------------------------------------
module ideq_datapath
   import ideq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int STEP  = STEP_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ideq_cmd_type             cmd,
   output ideq_stat_type            stat,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [IDX_W-1:0]  req_index,
   input  logic signed [DATA_W-1:0] req_data,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [LEN_W-1:0]         rsp_length
);

   localparam int AW       = $clog2(DEPTH);
   localparam int PW       = $clog2(DEPTH + 1);
   localparam int RW       = ((PW > IDX_W) ? PW : IDX_W) + 1;
   localparam int CW       = PW + 12;
   localparam int STEP_MOD = STEP % DEPTH;

   localparam logic signed [RW-1:0] DEPTH_S = RW'(DEPTH);

   // Window pointers, base offset and clearing counter.
   logic [PW-1:0] first_ff, first_in;
   logic [PW-1:0] next_ff, next_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] clr_cnt_ff;

   // Per-transaction registers between acceptance and response.
   logic [STAT_W-1:0] status_ff;
   logic              rd_ok_ff;
   logic              zero_ff;
   logic [AW-1:0]     addr_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]  rsp_length_ff;

   // Decode results.
   logic signed [RW-1:0] idx_ext;
   logic signed [RW-1:0] next_z;
   logic signed [RW-1:0] res;
   logic                 res_neg;
   logic                 res_ge_next;
   logic                 res_ge_depth;
   logic                 unshift_full;
   logic [AW:0]          base_sum;
   logic [AW-1:0]        base_new;
   logic [STAT_W-1:0]    status;
   logic                 do_wr;
   logic                 do_rd;
   logic                 do_zero;
   logic                 new_base;
   logic [PW-1:0]        tgt;
   logic [PW:0]          slot_diff;
   logic [PW:0]          slot_wrap;
   logic [AW-1:0]        slot;

   // Memory port signals.
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [DATA_W-1:0] ram_rd_data;

   // Resolve the request index; a negative one counts back from next.
   assign idx_ext      = RW'(req_index);
   assign next_z       = RW'({1'b0, next_ff});
   assign res          = req_index[IDX_W-1] ? (idx_ext + next_z) : idx_ext;
   assign res_neg      = res[RW-1];
   assign res_ge_next  = !res_neg && (res >= next_z);
   assign res_ge_depth = !res_neg && (res >= DEPTH_S);

   // Renumbering on an unshift at the bottom: refusal check and new base.
   assign unshift_full = (CW'(next_ff) + CW'(STEP)) > CW'(DEPTH);
   assign base_sum     = {1'b0, base_ff} + (AW+1)'(STEP_MOD);
   assign base_new     = (base_sum >= (AW+1)'(DEPTH)) ?
                         AW'(base_sum - (AW+1)'(DEPTH)) : base_sum[AW-1:0];

   // Operation decode: at most one store access at acceptance and the pointer updates.
   always_comb begin
      status   = ST_OK;
      do_wr    = 1'b0;
      do_rd    = 1'b0;
      do_zero  = 1'b0;
      new_base = 1'b0;
      tgt      = '0;
      first_in = first_ff;
      next_in  = next_ff;
      base_in  = base_ff;
      case (req_op)
         OP_GET: begin
            if (res_neg || res_ge_next) begin
               status = ST_BAD;
            end else begin
               do_rd = 1'b1;
               tgt   = res[PW-1:0];
            end
         end
         OP_PUT: begin
            if (res_neg) begin
               status = ST_BAD;
            end else if (res_ge_depth) begin
               status = ST_FULL;
            end else begin
               do_wr = 1'b1;
               tgt   = res[PW-1:0];
               if (res_ge_next) begin
                  next_in = res[PW-1:0] + PW'(1);
               end
            end
         end
         OP_PUSH: begin
            if (next_ff >= PW'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               do_wr   = 1'b1;
               tgt     = next_ff;
               next_in = next_ff + PW'(1);
            end
         end
         OP_POP: begin
            if (next_ff <= first_ff) begin
               status = ST_BAD;
            end else begin
               do_rd   = 1'b1;
               do_zero = 1'b1;
               tgt     = next_ff - PW'(1);
               next_in = next_ff - PW'(1);
            end
         end
         OP_UNSHIFT: begin
            if (first_ff == '0) begin
               if (unshift_full) begin
                  status = ST_FULL;
               end else begin
                  do_wr    = 1'b1;
                  new_base = 1'b1;
                  base_in  = base_new;
                  tgt      = PW'(STEP - 1);
                  first_in = PW'(STEP - 1);
                  next_in  = next_ff + PW'(STEP);
               end
            end else begin
               do_wr    = 1'b1;
               tgt      = first_ff - PW'(1);
               first_in = first_ff - PW'(1);
            end
         end
         OP_SHIFT: begin
            if (first_ff >= next_ff) begin
               status = ST_BAD;
            end else begin
               do_rd    = 1'b1;
               do_zero  = 1'b1;
               tgt      = first_ff;
               first_in = first_ff + PW'(1);
            end
         end
         default: status = ST_BAD;
      endcase
   end

   // Physical slot of the logical target, modulo the store depth.
   assign slot_diff = {1'b0, tgt} - (PW+1)'(new_base ? base_new : base_ff);
   assign slot_wrap = slot_diff + (PW+1)'(DEPTH);
   assign slot      = slot_diff[PW] ? slot_wrap[AW-1:0] : slot_diff[AW-1:0];

   // Store port selection: clearing sweep, access at acceptance, or the
   // zeroing write of a pop or shift when the response is handed over.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot;
      ram_wr_data = req_data;
      if (cmd.clear_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else if (cmd.accept) begin
         ram_wr_en   = do_wr;
      end else if (cmd.finish) begin
         ram_wr_en   = zero_ff;
         ram_wr_addr = addr_ff;
         ram_wr_data = '0;
      end
   end

   assign ram_rd_en = cmd.accept && do_rd;

   ideq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (slot),
      .rd_data (ram_rd_data)
   );

   // Control state: pointers, base offset and clearing counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= '0;
         next_ff    <= '0;
         base_ff    <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.accept) begin
            first_ff <= first_in;
            next_ff  <= next_in;
            base_ff  <= base_in;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
      end
   end

   assign stat.clear_done = cmd.clear_step && (clr_cnt_ff == AW'(DEPTH - 1));

   // Transaction details kept until the response is built.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff <= status;
         rd_ok_ff  <= do_rd;
         zero_ff   <= do_zero;
         addr_ff   <= slot;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_value_ff  <= rd_ok_ff ? ram_rd_data : '0;
         rsp_status_ff <= status_ff;
         rsp_length_ff <= LEN_W'(next_ff - first_ff);
      end
   end

   assign rsp_value  = $signed(rsp_value_ff);
   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

endmodule

// ===== rtl/core/indexed_deque_top.sv =====
// ----------------------------------------------------------------------------
// Indexed deque top level
// A deque of signed 64-bit words in a fixed store with get and put at an
// index, push and pop at the top and unshift and shift at the bottom.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_op, req_index, req_data
//   rsp_      out        rsp_valid/rsp_ready   rsp_value, rsp_status, rsp_length
//
// In each transaction the store is accessed in the cycle it is accepted, and
// the registered read data enters the output register when the controller
// finishes the transaction, which waits until the output register is free.
// After reset a clearing sweep writes every store word to zero, during which
// req_ready is low. A response left waiting in the output register does not
// hold up acceptance of the next transaction but stalls its finish; req_ready
// returns in the cycle after the output register takes the pending result.
// ----------------------------------------------------------------------------
module indexed_deque_top
   import ideq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int STEP  = STEP_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [IDX_W-1:0]  req_index,
   input  logic signed [DATA_W-1:0] req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [LEN_W-1:0]         rsp_length
);

   ideq_cmd_type  cmd;
   ideq_stat_type stat;

   // Sequencing of clearing, acceptance and response hand-over.
   ideq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Pointers, store and response formation.
   ideq_datapath #(
      .DEPTH (DEPTH),
      .STEP  (STEP)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_op     (req_op),
      .req_index  (req_index),
      .req_data   (req_data),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .rsp_length (rsp_length)
   );

   // Only one transaction is in flight: ready drops after an acceptance.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // The status code is never the unused encoding.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("undefined status code on response");

   // A failed transaction always answers with a zero word.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_value == '0))
      else $error("non-zero value on a failed transaction");

   // A fresh response is only produced out of a finished transaction.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(!req_ready))
      else $error("response appeared without a transaction");

endmodule

// ===== test/indexed_deque_top_tb.sv =====
// ----------------------------------------------------------------------------
// Indexed deque testbench
// Drives get, put, push, pop, unshift and shift transactions into the deque
// and checks every reply field against a shadow copy of the store and its
// first and next pointers. Directed cases cover the empty, extreme and
// refused cases; random runs of operation sequences reach renumbering at
// the bottom and a long receiver stall fills the block until it stalls.
// ----------------------------------------------------------------------------
module indexed_deque_top_tb
   import ideq_pkg::*;
();

   localparam int STORE_DEPTH   = DEPTH_DEF;
   localparam int RENUMBER_STEP = STEP_DEF;
   localparam int HALF_PERIOD   = 6;
   localparam longint RUN_LIMIT = 64'd6_000_000;

   // Operation codes that the block does not define.
   localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [IDX_W-1:0]  IDX_MIN  = {1'b1, {(IDX_W-1){1'b0}}};
   localparam logic signed [IDX_W-1:0]  IDX_MAX  = {1'b0, {(IDX_W-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
   } deque_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_op = OP_GET;
   logic signed [IDX_W-1:0]  req_index = '0;
   logic signed [DATA_W-1:0] req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [LEN_W-1:0]         rsp_length;

   // Shadow state of the deque.
   logic [DATA_W-1:0] shadow_words [STORE_DEPTH];
   int first_pos  = 0;
   int next_pos   = 0;
   int ring_base  = 0;

   deque_reply_type owed_replies [$];

   int sender_idle_pct = 0;
   int recv_idle_pct   = 0;
   int ready_hold      = 0;

   int items_sent      = 0;
   int replies_checked = 0;
   int mismatch_count  = 0;
   int renumber_count  = 0;
   int full_seen       = 0;
   int bad_seen        = 0;

   indexed_deque_top #(
      .DEPTH(STORE_DEPTH),
      .STEP (RENUMBER_STEP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .req_index (req_index),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .rsp_status(rsp_status),
      .rsp_length(rsp_length)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Physical slot of a logical index under the current ring base.
   function automatic int slot_for(input int logical);
      return (logical % STORE_DEPTH + STORE_DEPTH - ring_base) % STORE_DEPTH;
   endfunction

   // Store a word at a logical index, extending the top of the window.
   function automatic void store_word(input int logical, input logic [DATA_W-1:0] word);
      shadow_words[slot_for(logical)] = word;
      if (logical >= next_pos)
         next_pos = logical + 1;
   endfunction

   // Apply one operation to the shadow deque and return the reply it owes.
   function automatic deque_reply_type apply_deque_op(input logic [OP_W-1:0] op,
                                                      input logic signed [IDX_W-1:0] idx,
                                                      input logic signed [DATA_W-1:0] data);
      deque_reply_type r;
      int pos;
      int s;
      r.value  = '0;
      r.status = ST_OK;
      pos = int'(idx);
      if (pos < 0)
         pos += next_pos;
      case (op)
         OP_GET: begin
            if (pos < 0 || pos >= next_pos)
               r.status = ST_BAD;
            else
               r.value = shadow_words[slot_for(pos)];
         end
         OP_PUT: begin
            if (pos < 0)
               r.status = ST_BAD;
            else if (pos >= STORE_DEPTH)
               r.status = ST_FULL;
            else
               store_word(pos, data);
         end
         OP_PUSH: begin
            if (next_pos >= STORE_DEPTH)
               r.status = ST_FULL;
            else
               store_word(next_pos, data);
         end
         OP_POP: begin
            if (next_pos <= first_pos) begin
               r.status = ST_BAD;
            end else begin
               s = slot_for(next_pos - 1);
               r.value = shadow_words[s];
               shadow_words[s] = '0;
               next_pos--;
            end
         end
         OP_UNSHIFT: begin
            if (first_pos == 0 && next_pos + RENUMBER_STEP > STORE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // At the bottom every index moves up by one step.
               if (first_pos == 0) begin
                  ring_base = (ring_base + RENUMBER_STEP) % STORE_DEPTH;
                  first_pos += RENUMBER_STEP;
                  next_pos  += RENUMBER_STEP;
                  renumber_count++;
               end
               first_pos--;
               store_word(first_pos, data);
            end
         end
         OP_SHIFT: begin
            if (first_pos >= next_pos) begin
               r.status = ST_BAD;
            end else begin
               s = slot_for(first_pos);
               r.value = shadow_words[s];
               shadow_words[s] = '0;
               first_pos++;
            end
         end
         default: r.status = ST_BAD;
      endcase
      r.length = LEN_W'(next_pos - first_pos);
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(9, 0))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Index mostly near the live window, in plain or next-relative form. Wild
   // positive indices are kept off puts so the window does not jump upwards.
   function automatic logic signed [IDX_W-1:0] pick_index(input bit any_positive);
      logic signed [IDX_W-1:0] idx;
      int lo;
      int hi;
      int pos;
      lo  = (first_pos > 4) ? first_pos - 4 : 0;
      hi  = (next_pos + 8 < STORE_DEPTH) ? next_pos + 8 : STORE_DEPTH - 1;
      pos = $urandom_range(hi, lo);
      case ($urandom_range(7, 0))
         0: begin
            if (any_positive)
               idx = IDX_W'($urandom);
            else
               idx = IDX_W'(-int'($urandom_range(1024, 1)));
         end
         1, 2: idx = IDX_W'(pos - next_pos);
         default: idx = IDX_W'(pos);
      endcase
      return idx;
   endfunction

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 20) return OP_GET;
      if (roll < 36) return OP_PUT;
      if (roll < 54) return OP_PUSH;
      if (roll < 70) return OP_POP;
      if (roll < 84) return OP_UNSHIFT;
      if (roll < 97) return OP_SHIFT;
      return roll[0] ? OP_RSVD_HI : OP_RSVD_LO;
   endfunction

   // Offer one transaction and record its reply once the block accepts it.
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      req_data  <= data;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      owed_replies.push_back(apply_deque_op(op, idx, data));
      items_sent++;
   endtask

   task automatic send_random_op(input logic [OP_W-1:0] op);
      send_item(op, pick_index(op != OP_PUT), rand_word());
   endtask

   // Drop the request and wait until every reply owed has come back.
   task automatic wait_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_empty_and_codes();
      send_item(OP_GET, '0, '0);
      send_item(OP_POP, IDX_MIN, WORD_MAX);
      send_item(OP_SHIFT, '0, '0);
      send_item(OP_RSVD_LO, IDX_MAX, WORD_MIN);
      send_item(OP_RSVD_HI, -11'sd1, '1);
      wait_replies();
   endtask

   task automatic test_word_extremes();
      send_item(OP_PUSH, '0, WORD_MAX);
      send_item(OP_PUSH, IDX_MIN, WORD_MIN);
      send_item(OP_GET, -11'sd1, '0);
      send_item(OP_GET, -11'sd2, '0);
      send_item(OP_GET, -11'sd3, '0);
      send_item(OP_GET, 11'sd2, '0);
      // A put past the top leaves a zero gap behind it.
      send_item(OP_PUT, 11'sd5, rand_word());
      send_item(OP_GET, 11'sd3, '0);
      send_item(OP_GET, IDX_MAX, '0);
      wait_replies();
   endtask

   task automatic test_bottom_end();
      // Unshift with first at zero renumbers the window upwards.
      send_item(OP_UNSHIFT, '0, {$urandom, $urandom});
      send_item(OP_GET, 11'sd63, '0);
      send_item(OP_SHIFT, '0, '0);
      send_item(OP_GET, 11'sd63, '0);
      send_item(OP_PUT, 11'sd10, {$urandom, $urandom});
      send_item(OP_GET, 11'sd10, '0);
      send_item(OP_PUT, IDX_MIN, WORD_MAX);
      send_item(OP_POP, '0, '0);
      wait_replies();
   endtask

   // The receiver holds off for a long stretch while the sender keeps going.
   task automatic test_backpressure();
      int k;
      sender_idle_pct = 0;
      ready_hold = 90;
      for (k = 0; k < 24; k++)
         send_random_op((k % 3 == 0) ? OP_GET : OP_PUSH);
      wait_replies();
   endtask

   // Runs of one operation with random content, mixed with scattered noise.
   task automatic run_random_ops(input int count);
      int sent;
      int run_len;
      int kind;
      int k;
      logic [OP_W-1:0] run_op;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9, 0);
         if (next_pos > 700 && kind < 8)
            kind = 9;
         run_len = (kind == 5) ? $urandom_range(80, 20) : $urandom_range(30, 6);
         case (kind)
            5: run_op = OP_UNSHIFT;
            6: run_op = OP_SHIFT;
            7: run_op = OP_PUSH;
            8: run_op = OP_GET;
            9: run_op = OP_POP;
            default: run_op = OP_GET;
         endcase
         for (k = 0; k < run_len; k++)
            send_random_op((kind < 5 || $urandom_range(5, 0) == 0) ? pick_op() : run_op);
         sent += run_len;
      end
   endtask

   task automatic test_random();
      sender_idle_pct = 35;
      recv_idle_pct   = 54;
      run_random_ops(534);
      sender_idle_pct = 54;
      recv_idle_pct   = 35;
      run_random_ops(533);
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      run_random_ops(533);
      wait_replies();
   endtask

   // Fill the window to the full store and check the refusals.
   task automatic test_full_store();
      send_item(OP_PUT, IDX_MAX, rand_word());
      while (first_pos > 0)
         send_item(OP_UNSHIFT, pick_index(1'b1), rand_word());
      send_item(OP_UNSHIFT, '0, rand_word());
      send_item(OP_PUSH, '0, rand_word());
      send_item(OP_GET, IDX_MIN, '0);
      send_item(OP_GET, -11'sd1, '0);
      send_item(OP_PUT, IDX_MAX, rand_word());
      send_item(OP_POP, '0, '0);
      send_item(OP_SHIFT, '0, '0);
      send_item(OP_GET, IDX_MIN, '0);
      wait_replies();
   endtask

   // Receiver side: random stalls, or a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // Each reply is checked against the oldest one owed.
   always @(posedge clock) begin
      deque_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (owed_replies.size() == 0) begin
            report_mismatch("unrequested reply value", '0, rsp_value);
         end else begin
            want = owed_replies.pop_front();
            replies_checked++;
            if (rsp_value !== want.value)
               report_mismatch("value", want.value, rsp_value);
            if (rsp_status !== want.status)
               report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
            if (rsp_length !== want.length)
               report_mismatch("length", DATA_W'(want.length), DATA_W'(rsp_length));
            if (rsp_status === ST_FULL)
               full_seen++;
            if (rsp_status === ST_BAD)
               bad_seen++;
         end
      end
   end

   initial begin
      int k;
      for (k = 0; k < STORE_DEPTH; k++)
         shadow_words[k] = '0;
      sender_idle_pct = 35;
      recv_idle_pct   = 54;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_empty_and_codes();
      test_word_extremes();
      test_bottom_end();
      test_backpressure();
      test_random();
      test_full_store();

      repeat (16) @(posedge clock);
      $display("Ran %0d transactions across all six operations and both undefined codes,",
               items_sent);
      $display("with %0d replies checked, %0d bottom renumberings, %0d no-room, %0d bad.",
               replies_checked, renumber_count, full_seen, bad_seen);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #RUN_LIMIT;
      $display("Timed out with %0d replies outstanding", owed_replies.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ideq_pkg.sv
rtl/core/ideq_ram.sv
rtl/core/ideq_ctrl.sv
rtl/core/ideq_datapath.sv
rtl/core/indexed_deque_top.sv
test/indexed_deque_top_tb.sv
